[sv/hydrogen_bond_geometry_test_defines.svh]
// ----------------------------------------------------------------------------
// hydrogen bond geometry test: assertion macros
// concurrent checks, compiled out under synthesis
// ----------------------------------------------------------------------------
`ifndef HYDROGEN_BOND_GEOMETRY_TEST_DEFINES_SVH
`define HYDROGEN_BOND_GEOMETRY_TEST_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HBG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HBG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HBG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define HBG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/hbg_pkg.sv]
// ----------------------------------------------------------------------------
// hbg_pkg
// shared constants and register codes of the hydrogen bond geometry test
// ----------------------------------------------------------------------------
`default_nettype none

package hbg_pkg;

    // coordinate format
    localparam int C_COORD_WIDTH = 24;
    localparam int N_IN_FIELDS   = 9;

    // configuration registers
    localparam int DIST_W     = 23;
    localparam int COS_W      = 18;
    localparam int COS_FRAC   = 16;
    localparam int CM2_W      = 2 * COS_W;
    localparam int CFG_DATA_W = (DIST_W > COS_W) ? DIST_W : COS_W;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIST_CUTOFF      = 1'b0,
        REG_COS_ANGLE_CUTOFF = 1'b1
    } t_cfg_idx;

    // 1.0 nm and cos(150 deg)
    localparam logic [DIST_W-1:0]       DIST_RESET = 23'd65536;
    localparam logic signed [COS_W-1:0] COS_RESET  = -18'sd56756;

    // result word
    localparam int OUT_TDATA_W = 8;

endpackage

`default_nettype wire

[sv/hbg_mul.sv]
// ----------------------------------------------------------------------------
// hbg_mul
// unsigned wide multiplier in three register stages:
// chunk products, row sums, final sum
// ----------------------------------------------------------------------------
`default_nettype none

module hbg_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32,
    parameter int AC  = 16,
    parameter int BC  = 16
) (
    input  logic               i_clk,
    input  logic [2:0]         i_en,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);

    localparam int NA  = (A_W + AC - 1) / AC;
    localparam int NB  = (B_W + BC - 1) / BC;
    localparam int AXW = NA * AC;
    localparam int BXW = NB * BC;
    localparam int PPW = AC + BC;
    localparam int RW  = AC + BXW;
    localparam int SW  = AXW + BXW;
    localparam int P_W = A_W + B_W;

    logic [AXW-1:0] w_a;
    logic [BXW-1:0] w_b;
    logic [PPW-1:0] r_pp  [NA][NB];
    logic [RW-1:0]  r_row [NA];
    logic [RW-1:0]  n_row [NA];
    logic [SW-1:0]  n_sum;
    logic [P_W-1:0] r_p;

    assign w_a = AXW'(i_a);
    assign w_b = BXW'(i_b);

    // chunk products
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= PPW'(w_a[i*AC +: AC]) * PPW'(w_b[j*BC +: BC]);
                end
            end
        end
    end

    // one row per a-chunk
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (RW'(r_pp[i][j]) << (j * BC));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int i = 0; i < NA; i++) begin
                r_row[i] <= n_row[i];
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (SW'(r_row[i]) << (i * AC));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_p <= n_sum[P_W-1:0];
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

[sv/hydrogen_bond_geometry_test.sv]
// throughput: one word per cycle while the output is not stalled, in the eleven-stage pipeline whose
//   widest steps are the split partial-product multipliers (stages 5 to 10)
// an output stall holds the input only once all eleven stages are full
// reset (i_rst_n low, synchronous): pipeline emptied, cutoffs back to 1.0 nm
//   and cos(150 deg)
// ----------------------------------------------------------------------------
// hydrogen_bond_geometry_test
// geometric hydrogen bond criterion on acceptor, hydrogen and donor positions
// ----------------------------------------------------------------------------
`default_nettype none

`include "hydrogen_bond_geometry_test_defines.svh"

module hydrogen_bond_geometry_test #(
    parameter int  COORD_WIDTH = hbg_pkg::C_COORD_WIDTH,
    localparam int IN_TDATA_W  = ((hbg_pkg::N_IN_FIELDS * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave word: acceptor_x, acceptor_y, acceptor_z, hydrogen_x, hydrogen_y,
    // hydrogen_z, donor_x, donor_y, donor_z (lowest first, COORD_WIDTH each)
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [IN_TDATA_W-1:0]            i_s_tdata,
    // master word: within_distance, is_hbond (lowest first)
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [hbg_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [hbg_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [hbg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import hbg_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int DW    = W + 1;           // signed difference
    localparam int SQ    = 2 * W;           // product of two magnitudes
    localparam int NW    = SQ + 2;          // sum of three products
    localparam int HC    = (NW + 1) / 2;    // multiplier chunk
    localparam int PW    = 2 * NW;          // dot^2 and n1*n2
    localparam int RHS_W = PW + CM2_W;
    localparam int LHS_W = PW + 2 * COS_FRAC;
    localparam int CMP_W = (RHS_W > LHS_W) ? RHS_W : LHS_W;
    localparam int CUT_W = 2 * DIST_W;
    localparam int DCW   = (NW > CUT_W) ? NW : CUT_W;
    localparam int NS    = 11;              // register stages, output included

    typedef struct packed {
        logic dist_ok;
        logic zero;     // a vector of zero length
        logic dpos;     // dot product > 0
        logic dneg;     // dot product < 0
    } t_flg;

    // ------------------------------------------------------------------
    // configuration registers and derived squares
    // ------------------------------------------------------------------
    logic [DIST_W-1:0]       r_dist;
    logic signed [COS_W-1:0] r_cos;
    logic [CUT_W-1:0]        r_cut2;
    logic [CM2_W-1:0]        r_cm2;
    logic [COS_W-1:0]        w_cmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= DIST_RESET;
            r_cos  <= COS_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                REG_DIST_CUTOFF:      r_dist <= i_cfg_data[DIST_W-1:0];
                REG_COS_ANGLE_CUTOFF: r_cos  <= signed'(i_cfg_data[COS_W-1:0]);
                default:              r_dist <= r_dist;
            endcase
        end
    end

    assign w_cmag = r_cos[COS_W-1] ? COS_W'(-r_cos) : COS_W'(r_cos);

    // user must make config changes only while idle (unenforced); the register lag is then harmless
    always_ff @(posedge i_clk) begin
        r_cut2 <= CUT_W'(r_dist) * CUT_W'(r_dist);
        r_cm2  <= CM2_W'(w_cmag) * CM2_W'(w_cmag);
    end

    // ------------------------------------------------------------------
    // stage control: a stage loads when empty or when the next one loads
    // ------------------------------------------------------------------
    logic [NS:1] r_vld;
    logic [NS:1] w_en;

    always_comb begin
        w_en[NS] = !r_vld[NS] || i_m_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = w_en[1];

    // ------------------------------------------------------------------
    // stage 1: v1 = A - H, v2 = D - H as sign and magnitude
    // ------------------------------------------------------------------
    logic signed [W-1:0]  w_a  [3];
    logic signed [W-1:0]  w_h  [3];
    logic signed [W-1:0]  w_d  [3];
    logic signed [DW-1:0] w_v1 [3];
    logic signed [DW-1:0] w_v2 [3];
    logic [W-1:0]         r1_m1 [3];
    logic [W-1:0]         r1_m2 [3];
    logic [2:0]           r1_s1;
    logic [2:0]           r1_s2;
    logic                 r1_z1;
    logic                 r1_z2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i]  = signed'(i_s_tdata[i*W +: W]);
            w_h[i]  = signed'(i_s_tdata[(3+i)*W +: W]);
            w_d[i]  = signed'(i_s_tdata[(6+i)*W +: W]);
            w_v1[i] = DW'(w_a[i]) - DW'(w_h[i]);
            w_v2[i] = DW'(w_d[i]) - DW'(w_h[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r1_s1[i] <= w_v1[i][DW-1];
                r1_s2[i] <= w_v2[i][DW-1];
                r1_m1[i] <= w_v1[i][DW-1] ? W'(-w_v1[i]) : W'(w_v1[i]);
                r1_m2[i] <= w_v2[i][DW-1] ? W'(-w_v2[i]) : W'(w_v2[i]);
            end
            r1_z1 <= (w_v1[0] == '0) && (w_v1[1] == '0) && (w_v1[2] == '0);
            r1_z2 <= (w_v2[0] == '0) && (w_v2[1] == '0) && (w_v2[2] == '0);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: per-axis squares and dot product terms
    // ------------------------------------------------------------------
    logic [SQ-1:0] r2_sq1 [3];
    logic [SQ-1:0] r2_sq2 [3];
    logic [SQ-1:0] r2_pr  [3];
    logic [2:0]    r2_neg;
    logic          r2_z1;
    logic          r2_z2;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r2_sq1[i] <= SQ'(r1_m1[i]) * SQ'(r1_m1[i]);
                r2_sq2[i] <= SQ'(r1_m2[i]) * SQ'(r1_m2[i]);
                r2_pr[i]  <= SQ'(r1_m1[i]) * SQ'(r1_m2[i]);
            end
            r2_neg <= r1_s1 ^ r1_s2;
            r2_z1  <= r1_z1;
            r2_z2  <= r1_z2;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: |v1|^2, |v2|^2, positive and negative dot terms
    // ------------------------------------------------------------------
    logic [NW-1:0] w_pos;
    logic [NW-1:0] w_negs;
    logic [NW-1:0] r3_n1;
    logic [NW-1:0] r3_n2;
    logic [NW-1:0] r3_pos;
    logic [NW-1:0] r3_neg;
    logic          r3_zero;

    always_comb begin
        w_pos  = '0;
        w_negs = '0;
        for (int i = 0; i < 3; i++) begin
            if (r2_neg[i]) begin
                w_negs = w_negs + NW'(r2_pr[i]);
            end else begin
                w_pos = w_pos + NW'(r2_pr[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_n1   <= NW'(r2_sq1[0]) + NW'(r2_sq1[1]) + NW'(r2_sq1[2]);
            r3_n2   <= NW'(r2_sq2[0]) + NW'(r2_sq2[1]) + NW'(r2_sq2[2]);
            r3_pos  <= w_pos;
            r3_neg  <= w_negs;
            r3_zero <= r2_z1 || r2_z2;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: dot sign and magnitude, distance test
    // ------------------------------------------------------------------
    logic [NW:0]   w_pn;
    logic [NW-1:0] w_np;
    logic [NW-1:0] r4_dmag;
    logic [NW-1:0] r4_n1;
    logic [NW-1:0] r4_n2;
    t_flg          r_flg [4:NS-1];

    assign w_pn = (NW+1)'(r3_pos) - (NW+1)'(r3_neg);
    assign w_np = r3_neg - r3_pos;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_dmag           <= w_pn[NW] ? w_np : w_pn[NW-1:0];
            r4_n1             <= r3_n1;
            r4_n2             <= r3_n2;
            r_flg[4].dist_ok  <= DCW'(r3_n1) <= DCW'(r_cut2);
            r_flg[4].zero     <= r3_zero;
            r_flg[4].dpos     <= !w_pn[NW] && (w_pn != '0);
            r_flg[4].dneg     <= w_pn[NW];
        end
        // flags ride alongside the multipliers
        for (int k = 5; k <= NS - 1; k++) begin
            if (w_en[k]) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stages 5-7: dot^2 and |v1|^2 * |v2|^2
    // ------------------------------------------------------------------
    logic [PW-1:0] w_dd;
    logic [PW-1:0] w_nn;

    hbg_mul #(
        .A_W (NW),
        .B_W (NW),
        .AC  (HC),
        .BC  (HC)
    ) u_mul_dd (
        .i_clk (i_clk),
        .i_en  (w_en[7:5]),
        .i_a   (r4_dmag),
        .i_b   (r4_dmag),
        .o_p   (w_dd)
    );

    hbg_mul #(
        .A_W (NW),
        .B_W (NW),
        .AC  (HC),
        .BC  (HC)
    ) u_mul_nn (
        .i_clk (i_clk),
        .i_en  (w_en[7:5]),
        .i_a   (r4_n1),
        .i_b   (r4_n2),
        .o_p   (w_nn)
    );

    // ------------------------------------------------------------------
    // stages 8-10: rhs = n1 * n2 * cos^2, dot^2 delayed to match
    // ------------------------------------------------------------------
    logic [RHS_W-1:0] w_rhs;
    logic [PW-1:0]    r8_dd;
    logic [PW-1:0]    r9_dd;
    logic [PW-1:0]    r10_dd;

    hbg_mul #(
        .A_W (PW),
        .B_W (CM2_W),
        .AC  (HC),
        .BC  (COS_W)
    ) u_mul_rhs (
        .i_clk (i_clk),
        .i_en  (w_en[10:8]),
        .i_a   (w_nn),
        .i_b   (r_cm2),
        .o_p   (w_rhs)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r8_dd <= w_dd;
        end
        if (w_en[9]) begin
            r9_dd <= r8_dd;
        end
        if (w_en[10]) begin
            r10_dd <= r9_dd;
        end
    end

    // ------------------------------------------------------------------
    // stage 11: sign-aware angle decision, output register; a zero-length vector fails
    // cos >= 0: non-positive dot passes, else dot^2 <= rhs
    // cos <  0: non-negative dot always fails, else dot^2 >= rhs
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] w_lhs;
    logic [CMP_W-1:0] w_rhs_x;
    logic             w_le;
    logic             w_ge;
    logic             w_angle_ok;
    t_flg             w_f;
    logic             r_out_within;
    logic             r_out_hbond;

    assign w_f     = r_flg[NS-1];
    assign w_lhs   = CMP_W'(r10_dd) << (2 * COS_FRAC);
    assign w_rhs_x = CMP_W'(w_rhs);
    assign w_le    = w_lhs <= w_rhs_x;
    assign w_ge    = w_lhs >= w_rhs_x;

    always_comb begin
        if (w_f.zero) begin
            w_angle_ok = 1'b0;
        end else if (!r_cos[COS_W-1]) begin
            w_angle_ok = !w_f.dpos || w_le;
        end else begin
            w_angle_ok = w_f.dneg && w_ge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS]) begin
            r_out_within <= w_f.dist_ok;
            r_out_hbond  <= w_f.dist_ok && w_angle_ok;
        end
    end

    assign o_m_tvalid = r_vld[NS];
    assign o_m_tdata  = {(OUT_TDATA_W-2)'(0), r_out_hbond, r_out_within};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `HBG_ASSERT_NOW(a_hbond_needs_dist, i_clk, i_rst_n, o_m_tvalid, !o_m_tdata[1] || o_m_tdata[0], "is_hbond without within_distance")
    `HBG_ASSERT_NEXT(a_zero_vec_no_hbond, i_clk, i_rst_n, w_en[NS] && r_vld[NS-1] && w_f.zero, !o_m_tdata[1], "zero-length vector gave a bond")
    `HBG_ASSERT_NOW(a_zero_len_within, i_clk, i_rst_n, r_vld[4] && (r4_n1 == '0), r_flg[4].dist_ok, "zero distance failed the cutoff")
    `HBG_ASSERT_NOW(a_ready_only_on_stall, i_clk, i_rst_n, !o_s_tready, o_m_tvalid && !i_m_tready, "input blocked without an output stall")

endmodule

`default_nettype wire
